@@ rtl/rrsp_pkg.sv @@
// Package for the round-robin slot picker: request and result beat types,
// field widths and the control state encoding. No dependencies.
package rrsp_pkg;

    localparam int ENDPOINT_W  = 3;
    localparam int SLOT_FULL_W = 16;
    localparam int SLOT_W      = 4;

    typedef struct packed {
        logic [ENDPOINT_W-1:0]  endpoint;
        logic [SLOT_FULL_W-1:0] slot_full;
    } request_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_PICK
    } state_t;

endpackage

@@ rtl/rrsp_pick.sv @@
// Round-robin priority pick over a slot mask, starting at a resume pointer.
// Pure combinational; no package dependencies.
module rrsp_pick #(
    parameter int SLOTS = 16
) (
    input  logic [SLOTS-1:0]               mask,
    input  logic [$clog2(SLOTS+1)-1:0]     ptr,
    output logic                           found,
    output logic [$clog2(SLOTS+1)-1:0]     pick,
    output logic [$clog2(SLOTS+1)-1:0]     next_ptr
);

    localparam int PTR_W = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] upper_mask;
    logic             upper_hit;
    logic [PTR_W-1:0] upper_idx;
    logic             any_hit;
    logic [PTR_W-1:0] any_idx;

    // Keep only slots at or above the pointer for the upward scan.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            upper_mask[i] = mask[i] && (PTR_W'(i) >= ptr);
        end
    end

    // Lowest set bit of each mask; walk downward so the lowest wins.
    always_comb
    begin
        upper_hit = 1'b0;
        upper_idx = '0;
        any_hit   = 1'b0;
        any_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (upper_mask[i])
            begin
                upper_hit = 1'b1;
                upper_idx = PTR_W'(i);
            end
            if (mask[i])
            begin
                any_hit = 1'b1;
                any_idx = PTR_W'(i);
            end
        end
    end

    // Upward scan first, then wrap from slot 0; miss clears the pointer.
    always_comb
    begin
        found    = any_hit;
        pick     = upper_hit ? upper_idx : any_idx;
        next_ptr = any_hit ? pick + PTR_W'(1) : '0;
    end

endmodule

@@ rtl/round_robin_slot_picker_top.sv @@
// Round-robin slot picker top level: per-endpoint resume pointer memory,
// request control and result register. Depends on rrsp_pkg and rrsp_pick.
//
// The accepting edge takes the synchronous pointer memory read and enters the
//   pick state; the pick and pointer write-back fill the pick state and load
//   the result register, and the result strobe (done) is registered from it.
// A new request is taken only after the read-modify-write of the pointer
//   memory is done; busy stays high for one cycle after each accept.
// Reset: rst_n clears the control state and the per-entry valid bits, so
//   every resume pointer reads as zero at once; no clearing pass is needed.
// The receiver cannot stall: each result beat is shown for one cycle only.
module round_robin_slot_picker_top #(
    parameter int SLOTS     = 16,
    parameter int ENDPOINTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rrsp_pkg::request_t request,
    output logic               done,
    output rrsp_pkg::result_t  result
);

    localparam int PTR_W = $clog2(SLOTS + 1);
    localparam int EP_W  = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;

    // Control state.
    rrsp_pkg::state_t state_reg;
    rrsp_pkg::state_t state_next;
    logic             done_reg;

    // Pointer memory and its per-entry valid bits (invalid reads as zero).
    logic [PTR_W-1:0]     ptr_mem [ENDPOINTS];
    logic [ENDPOINTS-1:0] valid_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic                 rd_valid_reg;

    // Captured request beat.
    logic [EP_W-1:0]                  ep_reg;
    logic [rrsp_pkg::SLOT_FULL_W-1:0] mask_reg;

    rrsp_pkg::result_t result_reg;

    logic                        accept;
    logic                        mem_we;
    logic [rrsp_pkg::ENDPOINT_W-1:0] ep_fold;
    logic [EP_W-1:0]             ep_idx;
    logic [PTR_W-1:0]            cur_ptr;
    logic                        pick_found;
    logic [PTR_W-1:0]            pick_idx;
    logic [PTR_W-1:0]            wr_ptr;

    assign accept = start && !busy;

    // Fold out-of-range endpoint numbers back into the table by repeated
    // subtraction; the input is only three bits wide.
    always_comb
    begin
        ep_fold = request.endpoint;
        for (int k = 0; k < (1 << rrsp_pkg::ENDPOINT_W) - 1; k++)
        begin
            if (32'(ep_fold) >= ENDPOINTS)
            begin
                ep_fold = ep_fold - rrsp_pkg::ENDPOINT_W'(ENDPOINTS);
            end
        end
        ep_idx = EP_W'(ep_fold);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrsp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rrsp_pkg::ST_PICK;
                end
            end
            rrsp_pkg::ST_PICK:
            begin
                state_next = rrsp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rrsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Output decode: hold busy through the pick cycle, write back there.
    always_comb
    begin
        busy   = 1'b0;
        mem_we = 1'b0;
        case (state_reg)
            rrsp_pkg::ST_IDLE:
            begin
                busy   = 1'b0;
                mem_we = 1'b0;
            end
            rrsp_pkg::ST_PICK:
            begin
                busy   = 1'b1;
                mem_we = 1'b1;
            end
            default:
            begin
                busy   = 1'b0;
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrsp_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= mem_we;
            if (mem_we)
            begin
                valid_reg[ep_reg] <= 1'b1;
            end
        end
    end

    // Pointer memory: synchronous read on accept, write-back in the pick
    // cycle. A new read can only follow the write, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_ptr_reg   <= ptr_mem[ep_idx];
            rd_valid_reg <= valid_reg[ep_idx];
            ep_reg       <= ep_idx;
            mask_reg     <= request.slot_full;
        end
        if (mem_we)
        begin
            ptr_mem[ep_reg] <= wr_ptr;
        end
    end

    // A never-written entry reads as a pointer of zero through its valid bit.
    assign cur_ptr = rd_valid_reg ? rd_ptr_reg : '0;

    // Mask bits beyond the slot count drop out in the size cast.
    rrsp_pick #(
        .SLOTS (SLOTS)
    ) u_pick (
        .mask     (SLOTS'(mask_reg)),
        .ptr      (cur_ptr),
        .found    (pick_found),
        .pick     (pick_idx),
        .next_ptr (wr_ptr)
    );

    // Result register: slot reads zero on a miss, truncated to the field.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            result_reg.found <= pick_found;
            result_reg.slot  <= pick_found ? rrsp_pkg::SLOT_W'(pick_idx) : '0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result beat follows exactly one pick cycle.
    a_done_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == rrsp_pkg::ST_PICK))
        else $error("result beat without a preceding pick cycle");

    // An accepted request always holds busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // A miss reports slot zero.
    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.slot == '0))
        else $error("miss reported with nonzero slot");

    // The written pointer never runs past the slot count.
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(wr_ptr) <= SLOTS))
        else $error("resume pointer out of range");

endmodule

@@ test/round_robin_slot_picker_top_test.sv @@
// Self-checking testbench for round_robin_slot_picker_top: a queued driver and
// a strobe monitor, checked against an in-bench pointer-table predictor.
// Depends on rrsp_pkg and the round_robin_slot_picker_top RTL.
module round_robin_slot_picker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int ENDPOINTS  = 8;
    localparam int SETTLE_CYC = 10;

    // DUT connections; every input is known from time zero
    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    rrsp_pkg::request_t request = '0;
    logic               busy;
    logic               done;
    rrsp_pkg::result_t  result;

    // Predictor state: one resume pointer per endpoint, range 0..SLOTS
    logic [4:0] resume_ptr [ENDPOINTS];

    rrsp_pkg::request_t req_backlog [$];   // requests not yet put on the bus
    rrsp_pkg::result_t  due_picks   [$];   // predicted picks, oldest first

    int idle_pct     = 0;        // chance in percent that the sender idles a cycle
    int errors       = 0;
    int accepted_cnt = 0;
    int checked_cnt  = 0;
    int found_cnt    = 0;
    int wrap_cnt     = 0;

    round_robin_slot_picker_top #(
        .SLOTS     (SLOTS),
        .ENDPOINTS (ENDPOINTS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Scan upward from the endpoint's pointer, then wrap from slot 0 up to
    // just below it. Advance the pointer past a hit; clear it on a miss.
    function automatic rrsp_pkg::result_t predict_pick(rrsp_pkg::request_t rq);
        int                ep;
        int                base;
        bit                hit;
        rrsp_pkg::result_t pick;
        ep   = int'(rq.endpoint) % ENDPOINTS;
        base = int'(resume_ptr[ep]);
        if (base > SLOTS)
            base = SLOTS;
        hit  = 1'b0;
        pick = '0;
        for (int i = base; i < SLOTS && !hit; i++)
        begin
            if (rq.slot_full[i])
            begin
                hit       = 1'b1;
                pick.slot = rrsp_pkg::SLOT_W'(i);
            end
        end
        for (int i = 0; i < base && !hit; i++)
        begin
            if (rq.slot_full[i])
            begin
                hit       = 1'b1;
                pick.slot = rrsp_pkg::SLOT_W'(i);
                wrap_cnt++;
            end
        end
        pick.found     = hit;
        resume_ptr[ep] = hit ? 5'(pick.slot) + 5'd1 : 5'd0;
        return pick;
    endfunction

    // Driver: predict on every accepted beat, hold start while busy, and
    // otherwise launch the next request unless this cycle is an idle one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                due_picks.push_back(predict_pick(request));
                accepted_cnt++;
            end
            if (start && busy)
            begin
                // hold the beat until the block takes it
            end
            else if (req_backlog.size() > 0 && $urandom_range(99, 0) >= idle_pct)
            begin
                start   <= 1'b1;
                request <= req_backlog.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each done strobe is one result beat; compare it with the
    // oldest prediction. There is no back-pressure on this side.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_picks.size() == 0)
            begin
                $error("unexpected result beat: found=%0b slot=%0d",
                       result.found, result.slot);
                errors++;
            end
            else
            begin
                rrsp_pkg::result_t want;
                want = due_picks.pop_front();
                checked_cnt++;
                if (want.found)
                    found_cnt++;
                if (result.found !== want.found)
                begin
                    $error("found mismatch: expected %0b, got %0b", want.found, result.found);
                    errors++;
                end
                if (result.slot !== want.slot)
                begin
                    $error("slot mismatch: expected %0d, got %0d", want.slot, result.slot);
                    errors++;
                end
            end
        end
    end

    task automatic add_request(input int ep, input logic [rrsp_pkg::SLOT_FULL_W-1:0] mask);
        rrsp_pkg::request_t rq;
        rq.endpoint  = rrsp_pkg::ENDPOINT_W'(ep);
        rq.slot_full = mask;
        req_backlog.push_back(rq);
    endtask

    // Random masks lean toward sparse and single-bit patterns so that the
    // pointer moves around and wraps often; empty and full masks show up too.
    function automatic logic [rrsp_pkg::SLOT_FULL_W-1:0] random_mask();
        logic [rrsp_pkg::SLOT_FULL_W-1:0] m;
        case ($urandom_range(9, 0))
            0:       m = '0;
            1, 2:    m = rrsp_pkg::SLOT_FULL_W'(1) << $urandom_range(SLOTS - 1, 0);
            3, 4, 5: m = rrsp_pkg::SLOT_FULL_W'($urandom & $urandom & $urandom);
            6, 7:    m = rrsp_pkg::SLOT_FULL_W'($urandom);
            8:       m = '1;
            default: m = rrsp_pkg::SLOT_FULL_W'($urandom) & 16'hF000;
        endcase
        return m;
    endfunction

    // Queue runs of requests on one endpoint, so back-to-back reads of a
    // pointer that was just written are common.
    task automatic add_random(input int n);
        int ep;
        int run;
        while (n > 0)
        begin
            ep  = $urandom_range(ENDPOINTS - 1, 0);
            run = $urandom_range(6, 1);
            for (int k = 0; k < run && n > 0; k++)
            begin
                add_request(ep, random_mask());
                n--;
            end
        end
    endtask

    // Wait until every queued request is in and every
    // predicted result has come back.
    task automatic drain();
        while (req_backlog.size() > 0 || start || due_picks.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        foreach (resume_ptr[e])
            resume_ptr[e] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty mask, full mask, walk to the top slot, pointer at
        // the end, wrapped search, clearing on a miss, both endpoint extremes.
        add_request(0, 16'h0000);
        add_request(0, 16'hFFFF);
        add_request(0, 16'hFFFF);
        add_request(0, 16'h8000);
        add_request(0, 16'h8000);
        add_request(0, 16'h0001);
        add_request(0, 16'h0001);
        add_request(0, 16'h0000);
        add_request(0, 16'h0001);
        add_request(7, 16'hAAAA);
        add_request(7, 16'h5555);
        add_request(7, 16'h5555);
        add_request(7, 16'h0004);
        add_request(7, 16'h0000);
        add_request(7, 16'h0002);
        add_request(3, 16'h8001);
        add_request(3, 16'h8001);
        add_request(3, 16'h8001);
        for (int e = 1; e < ENDPOINTS - 1; e++)
            if (e != 3)
                add_request(e, 16'hFFFF);
        add_request(5, 16'h7FFE);

        // No idling on the sender
        idle_pct = 0;
        add_random(320);
        drain();

        // Sender idle most of the time
        idle_pct = 81;
        add_random(340);
        drain();

        // The receiver cannot stall, so its stall phase runs at full rate
        idle_pct = 0;
        add_random(340);
        drain();

        // Light idling, standing in for both sides stalling
        idle_pct = 17;
        add_random(330);
        drain();

        repeat (SETTLE_CYC) @(posedge clk);
        if (due_picks.size() > 0)
        begin
            $error("%0d predicted results never arrived", due_picks.size());
            errors++;
        end

        $display("Checked %0d results for %0d requests: %0d picks, %0d via wrap, %0d misses.",
                 checked_cnt, accepted_cnt, found_cnt, wrap_cnt, checked_cnt - found_cnt);
        $display("Sender idle levels 0, 81 and 17 percent, with full drains between phases.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", due_picks.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
